// ----- rtl/chst_pkg.sv -----
// ----------------------------------------------------------------------------
// chst_pkg - coalesced hash table shared definitions
// Field widths, request and result codes and common types.
// ----------------------------------------------------------------------------
`default_nettype none

package chst_pkg;

  localparam int KEY_W     = 16;
  localparam int STAT_W    = 2;
  localparam int STEP_W    = 5;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [STEP_W-1:0] steps_t;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  localparam status_t ST_INSERTED  = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_FOUND     = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

  localparam steps_t STEPS_MAX = 5'd31;

endpackage

`default_nettype wire

// ----- rtl/chst_mod.sv -----
// ----------------------------------------------------------------------------
// chst_mod - key remainder unit
// Remainder of the key by TABLE_SIZE: reciprocal multiply for the quotient,
// then back-multiply and subtract, one registered stage each.
// ----------------------------------------------------------------------------
`default_nettype none

module chst_mod #(
  parameter int TABLE_SIZE = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire chst_pkg::key_t           key,
  output logic                          done,
  output logic [$clog2(TABLE_SIZE)-1:0] rem
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int KW = chst_pkg::KEY_W;
  localparam int PW = KW + 32;
  // floor(2^32 / TABLE_SIZE) + 1 gives the exact quotient of a 16-bit key
  localparam logic [31:0] RECIP = 32'(((64'd1 << 32) / TABLE_SIZE) + 1);
  localparam chst_pkg::key_t TS_K = KW'(TABLE_SIZE);

  logic            mul_r;
  logic            sub_r;
  logic            done_r;
  chst_pkg::key_t  key_r;
  chst_pkg::key_t  quot_r;
  logic [IW-1:0]   rem_r;
  logic [PW-1:0]   prod;
  chst_pkg::key_t  diff;

  always_comb begin
    prod = PW'(key_r) * PW'(RECIP);
    diff = key_r - quot_r * TS_K;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      sub_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= start;
      sub_r  <= mul_r;
      done_r <= sub_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= key;
    end
    if (mul_r) begin
      quot_r <= prod[PW-1:32];
    end
    if (sub_r) begin
      rem_r <= diff[IW-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ----- rtl/chst_mem.sv -----
// ----------------------------------------------------------------------------
// chst_mem - slot store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module chst_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 22
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/coalesced_hash_table.sv -----
// Steps: an insert into an empty home slot writes that slot; a search reads the
//   home slot and then follows one chain hop after another. A colliding insert
//   scans up to the lowest free slot, then walks every chain member; an insert
//   into a full table scans all TABLE_SIZE slots and reports full.
// Throughput: one request at a time; the next is taken at the earliest in the
//   cycle the result leaves. Reset: a clearing pass over every slot, no request.
// ----------------------------------------------------------------------------
// coalesced_hash_table - hash table with coalesced chaining
// Sequencer over a shared remainder unit and a slot store with one write port and one read port.
// Inserts fill the home slot or the lowest free slot linked from the chain
// tail; searches walk the chain from home.
// ----------------------------------------------------------------------------
`default_nettype none

module coalesced_hash_table #(
  parameter int TABLE_SIZE = 16
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire                     in_req_type,
  input  wire  chst_pkg::key_t    in_key,
  output logic                    out_valid,
  input  wire                     out_stall,
  output chst_pkg::status_t       out_status,
  output chst_pkg::steps_t        out_steps
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int PW = (CW > chst_pkg::STEP_W) ? CW : chst_pkg::STEP_W;
  localparam int KW = chst_pkg::KEY_W;
  localparam int EW = IW + KW + 2;
  localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SIZE - 1);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_MOD      = 4'd2;
  localparam logic [3:0] S_RD       = 4'd3;
  localparam logic [3:0] S_CHK      = 4'd4;
  localparam logic [3:0] S_SCAN_RD  = 4'd5;
  localparam logic [3:0] S_SCAN_CHK = 4'd6;
  localparam logic [3:0] S_WALK_RD  = 4'd7;
  localparam logic [3:0] S_WALK_CHK = 4'd8;
  localparam logic [3:0] S_WR_NEW   = 4'd9;

  logic [3:0]         state_r;
  logic               op_r;
  chst_pkg::key_t     key_r;
  logic [IW-1:0]      cur_r;
  logic [IW-1:0]      free_r;
  logic [IW-1:0]      clr_r;
  logic [CW-1:0]      pos_r;
  logic               out_valid_r;
  chst_pkg::status_t  out_status_r;
  chst_pkg::steps_t   out_steps_r;

  logic               accept;
  logic               mod_done;
  logic [IW-1:0]      mod_rem;

  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [EW-1:0]      mem_wdata;
  logic [IW-1:0]      mem_raddr;
  logic [EW-1:0]      mem_rdata;

  logic               r_used;
  logic               r_lv;
  logic [IW-1:0]      r_link;
  chst_pkg::key_t     r_key;

  logic [PW-1:0]      pos_ext;
  chst_pkg::steps_t   steps_sat;

  assign in_stall = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign accept   = in_valid && !in_stall;

  // entry layout: {used, link valid, link, key}
  assign r_used = mem_rdata[EW-1];
  assign r_lv   = mem_rdata[EW-2];
  assign r_link = mem_rdata[KW +: IW];
  assign r_key  = mem_rdata[KW-1:0];

  assign pos_ext   = PW'(pos_r);
  assign steps_sat = (pos_ext > PW'(chst_pkg::STEPS_MAX)) ? chst_pkg::STEPS_MAX
                                                          : pos_ext[chst_pkg::STEP_W-1:0];

  assign mem_raddr = ((state_r == S_SCAN_RD) || (state_r == S_SCAN_CHK)) ? free_r : cur_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_r;
    mem_wdata = {1'b1, 1'b0, {IW{1'b0}}, key_r};
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      S_CHK: begin
        mem_we = (op_r == chst_pkg::REQ_INSERT) && !r_used;
      end
      S_WALK_CHK: begin
        mem_we    = !r_lv;
        mem_wdata = {1'b1, 1'b1, free_r, r_key};
      end
      S_WR_NEW: begin
        mem_we    = 1'b1;
        mem_waddr = free_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  chst_mod #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .key   (in_key),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  chst_mem #(
    .DEPTH (TABLE_SIZE),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAST_SLOT) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (op_r == chst_pkg::REQ_INSERT) begin
            if (!r_used) begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_SCAN_RD;
            end
          end else if (!r_used || (r_key == key_r) || !r_lv) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_RD;
          end
        end
        S_SCAN_RD: begin
          state_r <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (!r_used) begin
            state_r <= S_WALK_RD;
          end else if (free_r == LAST_SLOT) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_SCAN_RD;
          end
        end
        S_WALK_RD: begin
          state_r <= S_WALK_CHK;
        end
        S_WALK_CHK: begin
          state_r <= r_lv ? S_WALK_RD : S_WR_NEW;
        end
        S_WR_NEW: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_req_type;
      key_r <= in_key;
    end
    unique case (state_r)
      S_MOD: begin
        if (mod_done) begin
          cur_r <= mod_rem;
          pos_r <= CW'(1);
        end
      end
      S_CHK: begin
        if (op_r == chst_pkg::REQ_INSERT) begin
          out_status_r <= chst_pkg::ST_INSERTED;
          out_steps_r  <= '0;
          free_r       <= '0;
        end else if (!r_used) begin
          out_status_r <= chst_pkg::ST_NOT_FOUND;
          out_steps_r  <= '0;
        end else if (r_key == key_r) begin
          out_status_r <= chst_pkg::ST_FOUND;
          out_steps_r  <= steps_sat;
        end else if (!r_lv) begin
          out_status_r <= chst_pkg::ST_NOT_FOUND;
          out_steps_r  <= '0;
        end else begin
          cur_r <= r_link;
          pos_r <= pos_r + 1'b1;
        end
      end
      S_SCAN_CHK: begin
        if (r_used) begin
          if (free_r == LAST_SLOT) begin
            out_status_r <= chst_pkg::ST_FULL;
            out_steps_r  <= '0;
          end else begin
            free_r <= free_r + 1'b1;
          end
        end
      end
      S_WALK_CHK: begin
        if (r_lv) begin
          cur_r <= r_link;
        end
      end
      S_WR_NEW: begin
        out_status_r <= chst_pkg::ST_INSERTED;
        out_steps_r  <= '0;
      end
      default: begin
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_steps  = out_steps_r;

endmodule

`default_nettype wire
